// ===== design/ssp_pkg.sv =====
// Shared types and constants for the shortest-path block.
package ssp_pkg;

  localparam int VERTEX_BITS   = 4;
  localparam int WEIGHT_IN_BITS = 16;
  localparam int DIST_BITS     = 20;
  localparam int COUNT_BITS    = 5;
  localparam int RESULT_LIMIT  = 16;
  localparam int CFG_DATA_BITS = 5;
  localparam int CFG_INDEX_BITS = 1;

  localparam logic [DIST_BITS-1:0] DIST_INF = '1;
  localparam logic [DIST_BITS-1:0] DIST_TOP = DIST_INF - DIST_BITS'(1);

  localparam logic MODE_LOAD = 1'b0;
  localparam logic MODE_RUN  = 1'b1;

  localparam logic [CFG_INDEX_BITS-1:0] CFG_VERTEX_COUNT = 1'b0;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_START_VERTEX = 1'b1;

  localparam logic [COUNT_BITS-1:0]  VERTEX_COUNT_RESET = 5'd16;
  localparam logic [VERTEX_BITS-1:0] START_VERTEX_RESET = 4'd0;

  typedef struct packed {
    logic                      mode;
    logic [VERTEX_BITS-1:0]    from_vertex;
    logic [VERTEX_BITS-1:0]    to_vertex;
    logic [WEIGHT_IN_BITS-1:0] edge_weight;
  } in_item_t;

  typedef struct packed {
    logic [VERTEX_BITS-1:0] vertex_index;
    logic [DIST_BITS-1:0]   distance;
    logic                   reachable;
    logic [VERTEX_BITS-1:0] predecessor;
    logic                   has_predecessor;
    logic                   last_result;
  } out_item_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_INIT,
    ST_SEARCH,
    ST_DECIDE,
    ST_RELAX,
    ST_EMIT
  } ssp_state_t;

  typedef struct packed {
    logic clear;
    logic take;
    logic j_reset;
    logic search_reset;
    logic init_scan;
    logic search_scan;
    logic settle;
    logic relax_scan;
    logic emit;
  } ssp_cmd_t;

  typedef struct packed {
    logic clear_last;
    logic run_accepted;
    logic j_at_n;
    logic j_at_last;
    logic found;
    logic emit_fire;
  } ssp_status_t;

endpackage

// ===== design/ssp_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module ssp_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== design/ssp_ctrl.sv =====
// Sequencer for clearing, loading, initialisation, search, relaxation and result emission.
module ssp_ctrl import ssp_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  ssp_status_t status,
  output ssp_cmd_t    cmd
);

  ssp_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_CLEAR:  if (status.clear_last) state_next = ST_IDLE;
      ST_IDLE:   if (status.run_accepted) state_next = ST_INIT;
      ST_INIT:   if (status.j_at_n) state_next = ST_SEARCH;
      ST_SEARCH: if (status.j_at_last) state_next = ST_DECIDE;
      ST_DECIDE: state_next = status.found ? ST_RELAX : ST_EMIT;
      ST_RELAX:  if (status.j_at_n) state_next = ST_SEARCH;
      ST_EMIT:   if (status.emit_fire && status.j_at_last) state_next = ST_IDLE;
      default:   state_next = ST_CLEAR;
    endcase
  end

  always_comb begin
    cmd = '0;
    case (state)
      ST_CLEAR: begin
        cmd.clear = 1'b1;
      end
      ST_IDLE: begin
        cmd.take    = 1'b1;
        cmd.j_reset = 1'b1;
      end
      ST_INIT: begin
        cmd.init_scan = 1'b1;
        if (status.j_at_n) begin
          cmd.j_reset      = 1'b1;
          cmd.search_reset = 1'b1;
        end
      end
      ST_SEARCH: begin
        cmd.search_scan = 1'b1;
      end
      ST_DECIDE: begin
        cmd.j_reset = 1'b1;
        cmd.settle  = status.found;
      end
      ST_RELAX: begin
        cmd.relax_scan = 1'b1;
        if (status.j_at_n) begin
          cmd.j_reset      = 1'b1;
          cmd.search_reset = 1'b1;
        end
      end
      ST_EMIT: begin
        cmd.emit = 1'b1;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

endmodule

// ===== design/ssp_datapath.sv =====
// Weight store, per-vertex distance state, nearest-vertex scan and result register.
module ssp_datapath import ssp_pkg::*; #(
  parameter int MAX_VERTICES = 16,
  parameter int WEIGHT_BITS  = 16
) (
  input  logic                      clk,
  input  logic                      rst,
  input  ssp_cmd_t                  cmd,
  output ssp_status_t               status,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  in_item_t                  in_item,
  output logic                      out_valid,
  input  logic                      out_stall,
  output out_item_t                 out_item,
  input  logic                      cfg_write,
  input  logic [CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [CFG_DATA_BITS-1:0]  cfg_data
);

  localparam int NV    = (MAX_VERTICES < RESULT_LIMIT) ? MAX_VERTICES : RESULT_LIMIT;
  localparam int IW    = $clog2(NV);
  localparam int CW    = $clog2(NV + 1);
  localparam int VW    = $clog2(MAX_VERTICES);
  localparam int AW    = 2 * VW;
  localparam int DEPTH = 1 << AW;
  localparam int SW    = ((DIST_BITS > WEIGHT_BITS) ? DIST_BITS : WEIGHT_BITS) + 1;

  // Configuration registers
  logic [COUNT_BITS-1:0]  vertex_count;
  logic [VERTEX_BITS-1:0] start_vertex;

  always_ff @(posedge clk) begin
    if (rst) begin
      vertex_count <= VERTEX_COUNT_RESET;
      start_vertex <= START_VERTEX_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        CFG_VERTEX_COUNT: vertex_count <= cfg_data;
        CFG_START_VERTEX: start_vertex <= cfg_data[VERTEX_BITS-1:0];
        default: ;
      endcase
    end
  end

  // Request intake
  logic in_accept, run_accept, load_we;
  logic [CW-1:0] n_calc, n_run;
  logic [IW-1:0] src_calc, src;

  assign in_stall   = !cmd.take;
  assign in_accept  = in_valid && cmd.take;
  assign run_accept = in_accept && (in_item.mode == MODE_RUN);
  assign load_we    = in_accept && (in_item.mode == MODE_LOAD)
                      && (32'(in_item.from_vertex) < MAX_VERTICES)
                      && (32'(in_item.to_vertex) < MAX_VERTICES);

  always_comb begin
    if (vertex_count == '0) begin
      n_calc = CW'(1);
    end else if (32'(vertex_count) > NV) begin
      n_calc = CW'(NV);
    end else begin
      n_calc = CW'(vertex_count);
    end
    src_calc = (32'(start_vertex) < 32'(n_calc)) ? IW'(start_vertex) : '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      n_run <= CW'(1);
    end else if (run_accept) begin
      n_run <= n_calc;
    end
  end

  always_ff @(posedge clk) begin
    if (run_accept) begin
      src <= src_calc;
    end
  end

  // Clearing pass over the weight store
  logic [AW-1:0] clear_addr;

  always_ff @(posedge clk) begin
    if (rst) begin
      clear_addr <= '0;
    end else if (cmd.clear) begin
      clear_addr <= clear_addr + AW'(1);
    end
  end

  // Scan counter and read issue
  logic [CW-1:0] j;
  logic [IW-1:0] j_idx, t, proc_idx, rd_idx, row;
  logic          j_below_n, issue, proc_valid, emit_fire;

  assign j_idx     = j[IW-1:0];
  assign j_below_n = j < n_run;
  assign issue     = (cmd.init_scan || cmd.relax_scan) && j_below_n;
  assign row       = cmd.init_scan ? src : t;

  always_ff @(posedge clk) begin
    if (rst) begin
      j <= '0;
    end else if (cmd.j_reset) begin
      j <= '0;
    end else if (issue || cmd.search_scan || emit_fire) begin
      j <= j + CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      proc_valid <= 1'b0;
    end else begin
      proc_valid <= issue;
    end
  end

  always_ff @(posedge clk) begin
    proc_idx <= j_idx;
  end

  // Weight store
  logic                   ram_we;
  logic [AW-1:0]          ram_waddr, ram_raddr;
  logic [WEIGHT_BITS-1:0] ram_wdata, rdata;

  assign ram_we    = cmd.clear || load_we;
  assign ram_waddr = cmd.clear ? clear_addr
                               : {VW'(in_item.from_vertex), VW'(in_item.to_vertex)};
  assign ram_wdata = cmd.clear ? '0 : WEIGHT_BITS'(in_item.edge_weight);
  assign ram_raddr = {VW'(row), VW'(j_idx)};

  ssp_ram #(
    .WIDTH (WEIGHT_BITS),
    .DEPTH (DEPTH)
  ) u_weight_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (rdata)
  );

  // Per-vertex state
  logic [DIST_BITS-1:0] best     [NV];
  logic [IW-1:0]        pred     [NV];
  logic                 pred_ok  [NV];
  logic                 settled  [NV];

  logic [DIST_BITS-1:0] near;
  logic                 found;
  logic [DIST_BITS-1:0] best_rd, addend, cand;
  logic [SW-1:0]        sum;
  logic                 settled_rd, w_nz;

  assign rd_idx     = (cmd.init_scan || cmd.relax_scan) ? proc_idx : j_idx;
  assign best_rd    = best[rd_idx];
  assign settled_rd = settled[rd_idx];

  // Saturate the path sum so that it stays finite
  assign w_nz   = rdata != '0;
  assign addend = cmd.init_scan ? '0 : near;
  assign sum    = SW'(addend) + SW'(rdata);
  assign cand   = (sum > SW'(DIST_TOP)) ? DIST_TOP : sum[DIST_BITS-1:0];

  always_ff @(posedge clk) begin
    if (proc_valid && cmd.init_scan) begin
      best[proc_idx]    <= (proc_idx == src) ? '0 : (w_nz ? cand : DIST_INF);
      pred[proc_idx]    <= src;
      pred_ok[proc_idx] <= w_nz;
      settled[proc_idx] <= proc_idx == src;
    end else if (proc_valid && cmd.relax_scan && !settled_rd && w_nz && (best_rd > cand)) begin
      best[proc_idx]    <= cand;
      pred[proc_idx]    <= t;
      pred_ok[proc_idx] <= 1'b1;
    end
    if (cmd.settle) begin
      settled[t] <= 1'b1;
    end
  end

  // Nearest unsettled vertex; strict compare keeps the lowest index on ties
  always_ff @(posedge clk) begin
    if (rst) begin
      found <= 1'b0;
    end else if (cmd.search_reset) begin
      found <= 1'b0;
    end else if (cmd.search_scan && !settled_rd && (best_rd < near)) begin
      found <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.search_reset) begin
      near <= DIST_INF;
    end else if (cmd.search_scan && !settled_rd && (best_rd < near)) begin
      near <= best_rd;
      t    <= j_idx;
    end
  end

  // Result register
  logic j_at_last;

  assign j_at_last = j == (n_run - CW'(1));
  assign emit_fire = cmd.emit && (!out_valid || !out_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit_fire) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_fire) begin
      out_item.vertex_index    <= VERTEX_BITS'(j_idx);
      out_item.distance        <= best_rd;
      out_item.reachable       <= best_rd != DIST_INF;
      out_item.predecessor     <= pred_ok[j_idx] ? VERTEX_BITS'(pred[j_idx]) : '0;
      out_item.has_predecessor <= pred_ok[j_idx];
      out_item.last_result     <= j_at_last;
    end
  end

  assign status.clear_last   = clear_addr == '1;
  assign status.run_accepted = run_accept;
  assign status.j_at_n       = j == n_run;
  assign status.j_at_last    = j_at_last;
  assign status.found        = found;
  assign status.emit_fire    = emit_fire;

`ifndef ASSERT_OFF
  a_settle_needs_found: assert property (@(posedge clk) disable iff (rst)
    cmd.settle |-> found)
    else $error("vertex settled without a candidate");

  a_pick_unsettled: assert property (@(posedge clk) disable iff (rst)
    (cmd.search_scan && found) |-> !settled[t])
    else $error("search picked a settled vertex");

  a_scan_in_range: assert property (@(posedge clk) disable iff (rst)
    j <= n_run)
    else $error("scan index ran past vertex count");

  a_result_from_emit: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(cmd.emit))
    else $error("result shown outside emission");
`endif

endmodule

// ===== design/single_source_shortest_path_top.sv =====
// Dijkstra shortest paths over a dense weight matrix. After reset the block sweeps the
// weight store's 2^(2*ceil(log2 MAX_VERTICES)) entries to zero, one entry a cycle (256
// entries by default), and takes no request meanwhile. A load request writes one weight
// as it is taken and the next request may follow at once. A run request first reads the
// source's row to set the starting distances, then settles vertices one by one: each
// pass scans the n vertices in use for the nearest unsettled one, one vertex a cycle
// through the shared compare, then reads the settled vertex's row out of the weight RAM
// and relaxes it, one RAM read a cycle. The n results then stream out one a cycle while
// the output is not stalled; no request is taken until the last result is loaded into
// the output register.
module single_source_shortest_path_top import ssp_pkg::*; #(
  parameter int MAX_VERTICES = 16,
  parameter int WEIGHT_BITS  = 16
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  in_item_t                  in_item,
  output logic                      out_valid,
  input  logic                      out_stall,
  output out_item_t                 out_item,
  input  logic                      cfg_write,
  input  logic [CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [CFG_DATA_BITS-1:0]  cfg_data
);

  ssp_cmd_t    cmd;
  ssp_status_t status;

  ssp_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .status (status),
    .cmd    (cmd)
  );

  ssp_datapath #(
    .MAX_VERTICES (MAX_VERTICES),
    .WEIGHT_BITS  (WEIGHT_BITS)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .status    (status),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

endmodule
